/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check an implication on every rising clk edge, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mapb_pkg.sv */
// ----------------------------------------------------------------------------
// mapb_pkg
// Widths, register indexes and defaults of the running-average pitch bend.
// ----------------------------------------------------------------------------
`default_nettype none

package mapb_pkg;

  // Field widths
  localparam int SAMPLE_W     = 14;
  localparam int NARROW_W     = 10;
  localparam int NARROW_SHIFT = 4;
  localparam int BYTE7_W      = 7;
  localparam int BYTE7_SHIFT  = 7;
  localparam int WLEN_W       = 7;
  localparam int CHAN_W       = 4;
  localparam int BEND_CHAN_W  = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_ADC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHANNEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_OFFSET = 2'd3;

  // Default window depth
  localparam int MAX_WINDOW_DEF = 64;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

/* hw/rtl/mapb_if.sv */
// ----------------------------------------------------------------------------
// mapb_if
// Valid/ready channels for samples in and pitch bend results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mapb_sample_if
  import mapb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mapb_bend_if
  import mapb_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [BEND_CHAN_W-1:0] bend_channel;
  logic [BYTE7_W-1:0]     bend_low;
  logic [BYTE7_W-1:0]     bend_high;

  modport source (output valid, output bend_channel, output bend_low,
                  output bend_high, input ready);
  modport sink   (input valid, input bend_channel, input bend_low,
                  input bend_high, output ready);
endinterface

`default_nettype wire

/* hw/rtl/moving_average_pitch_bend_core.sv */
// With averaging off an accepted sample goes straight to the emit step; with
// averaging on it passes the ring read, sum update and bit-serial divide first.
// A new sample is taken only in idle, after the last one has left the emit step.
// A result waits in the output register while the next sample is taken.
// Synchronous reset (rst_n low) clears state, configuration, sum, slot, fill
// count, last value sent and out valid; the ring memory needs no clearing pass.
// ----------------------------------------------------------------------------
// moving_average_pitch_bend_core
// Running average over a ring of samples with a single restoring divider,
// emitting a pitch bend beat whenever the averaged value changes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module moving_average_pitch_bend_core
  import mapb_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  mapb_sample_if.sink                in_chan,
  mapb_bend_if.source                out_chan
);

  localparam int SLOT_W = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int STEP_W = $clog2(SUM_W);
  localparam int CMP_W  = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [WLEN_W-1:0]      wlen_r;
  logic                   narrow_r;
  logic [CHAN_W-1:0]      base_ch_r;
  logic [CHAN_W-1:0]      ch_off_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [CNT_W-1:0]       fill_r;
  logic [SAMPLE_W-1:0]    last_sent_r;
  logic [SAMPLE_W-1:0]    val_r;
  logic [SAMPLE_W-1:0]    rdata_r;
  logic [SUM_W-1:0]       quot_r;
  logic [CNT_W-1:0]       rem_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r;
  logic [BEND_CHAN_W-1:0] out_ch_r;
  logic [BYTE7_W-1:0]     out_low_r;
  logic [BYTE7_W-1:0]     out_high_r;

  logic [SAMPLE_W-1:0]    mem [MAX_WINDOW];

  logic [CNT_W-1:0]       eff_len;
  logic                   avg_on;
  logic                   in_fire;
  logic [SAMPLE_W-1:0]    val_nxt;
  logic                   ring_full;
  logic [SAMPLE_W-1:0]    old_val;
  logic [CNT_W-1:0]       slot_inc;
  logic [CNT_W-1:0]       fill_nxt;
  logic [CNT_W:0]         rem_sh;
  logic [CNT_W+1:0]       diff;
  logic [SAMPLE_W-1:0]    avg_val;
  logic                   changed;
  logic                   out_free;

  // Clamp the window length to the ring depth
  always_comb begin
    if (CMP_W'(wlen_r) > CMP_W'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(wlen_r);
    end
  end

  assign avg_on   = (eff_len >= CNT_W'(2));
  assign in_fire  = in_chan.valid && (state_r == ST_IDLE);
  assign in_chan.ready = (state_r == ST_IDLE);

  // Widen narrow samples
  always_comb begin
    if (narrow_r) begin
      val_nxt = {in_chan.sample[NARROW_W-1:0], NARROW_SHIFT'(0)};
    end else begin
      val_nxt = in_chan.sample;
    end
  end

  // Oldest sample leaves the sum only once the ring is full
  assign ring_full = (fill_r == eff_len);
  assign old_val   = ring_full ? rdata_r : '0;
  assign slot_inc  = CNT_W'(slot_r) + CNT_W'(1);
  assign fill_nxt  = (fill_r < eff_len) ? fill_r + CNT_W'(1) : fill_r;

  // One restoring divide step: shift in a dividend bit, trial subtract
  assign rem_sh = {rem_r, quot_r[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, fill_r};

  assign avg_val  = quot_r[SAMPLE_W-1:0];
  assign changed  = (avg_val != last_sent_r);
  assign out_free = !out_valid_r || out_chan.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = avg_on ? ST_RD : ST_EMIT;
        end
      end
      ST_RD:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!changed || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wlen_r      <= '0;
      narrow_r    <= 1'b0;
      base_ch_r   <= '0;
      ch_off_r    <= '0;
      sum_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      last_sent_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WINDOW_LENGTH: begin
            wlen_r <= cfg_wdata[WLEN_W-1:0];
            sum_r  <= '0;
            slot_r <= '0;
            fill_r <= '0;
          end
          REG_NARROW_ADC:     narrow_r  <= cfg_wdata[0];
          REG_BASE_CHANNEL:   base_ch_r <= cfg_wdata[CHAN_W-1:0];
          REG_CHANNEL_OFFSET: ch_off_r  <= cfg_wdata[CHAN_W-1:0];
        endcase
      end else if (state_r == ST_UPD) begin
        sum_r  <= sum_r - SUM_W'(old_val) + SUM_W'(val_r);
        slot_r <= (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
        fill_r <= fill_nxt;
      end
      // Hand the beat over, or drop valid once taken
      if (state_r == ST_EMIT && changed && out_free) begin
        out_valid_r <= 1'b1;
        last_sent_r <= avg_val;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: sample hold, divider registers and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r  <= val_nxt;
      quot_r <= SUM_W'(val_nxt);
    end
    if (state_r == ST_UPD) begin
      quot_r <= sum_r - SUM_W'(old_val) + SUM_W'(val_r);
      rem_r  <= '0;
      step_r <= STEP_W'(SUM_W - 1);
    end
    if (state_r == ST_DIV) begin
      if (!diff[CNT_W+1]) begin
        rem_r  <= diff[CNT_W-1:0];
        quot_r <= {quot_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[CNT_W-1:0];
        quot_r <= {quot_r[SUM_W-2:0], 1'b0};
      end
      step_r <= step_r - STEP_W'(1);
    end
    if (state_r == ST_EMIT && changed && out_free) begin
      out_ch_r   <= BEND_CHAN_W'(base_ch_r) + BEND_CHAN_W'(ch_off_r);
      out_low_r  <= avg_val[BYTE7_W-1:0];
      out_high_r <= BYTE7_W'(avg_val >> BYTE7_SHIFT);
    end
  end

  // Ring memory: read in the fetch step, write in the update step
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rdata_r <= mem[slot_r];
    end
    if (state_r == ST_UPD) begin
      mem[slot_r] <= val_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.bend_channel = out_ch_r;
  assign out_chan.bend_low     = out_low_r;
  assign out_chan.bend_high    = out_high_r;

  `ASSERT_CLK(a_fill_bounded, fill_r <= CNT_W'(MAX_WINDOW), "fill count above ring depth")
  `ASSERT_IMPL(a_div_nonzero, state_r == ST_DIV, fill_r != '0, "divide by zero count")
  `ASSERT_IMPL(a_beat_matches_last, $rose(out_valid_r),
               {out_high_r, out_low_r} == last_sent_r, "beat differs from last value sent")
  `ASSERT_IMPL(a_busy_not_ready, state_r != ST_IDLE, !in_chan.ready,
               "sample taken while sequencer busy")

endmodule

`default_nettype wire
